// File: rtl/delimited_key_value_parser_core_assert.svh
// Assertion macros for the parser modules, used by the result sequencer.
`ifndef DELIMITED_KEY_VALUE_PARSER_CORE_ASSERT_SVH
`define DELIMITED_KEY_VALUE_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DKVP_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("parser assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DKVP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("parser assertion failed");

`endif

// File: rtl/dkvp_pkg.sv
// Shared constants and types of the delimited key/value parser.
`timescale 1ns / 1ps

package dkvp_pkg;

    localparam int KEY_BITS    = 32;
    localparam int LENGTH_BITS = 16;

    // Configuration register indexes and reset values
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TERM_FIRST  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TERM_SECOND = 1'b1;
    localparam logic [7:0] TERM_FIRST_RESET  = 8'hC0;
    localparam logic [7:0] TERM_SECOND_RESET = 8'h80;

    // Result kinds
    localparam logic [1:0] KIND_VALUE  = 2'd0;
    localparam logic [1:0] KIND_PAIR   = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    // Finish status codes
    localparam logic [1:0] ST_NORMAL    = 2'd0;
    localparam logic [1:0] ST_ZERO_STOP = 2'd1;
    localparam logic [1:0] ST_EMPTY_KEY = 2'd2;

    // Group queue between front and back
    localparam int QPTR_BITS   = 2;
    localparam int QUEUE_DEPTH = 1 << QPTR_BITS;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       payload_end;
    } in_req_t;

    typedef struct packed {
        logic [1:0]                    kind;
        logic signed [KEY_BITS-1:0]    pair_key;
        logic [7:0]                    data_byte;
        logic [LENGTH_BITS-1:0]        value_length;
        logic [1:0]                    finish_status;
        logic                          run_last;
    } result_t;

    typedef struct packed {
        logic                      en;
        logic [CFG_INDEX_BITS-1:0] index;
        logic [7:0]                data;
    } cfg_wr_t;

    // All results caused by one request: up to two value bytes, a pair
    // completion and a payload finish, emitted in that order.
    typedef struct packed {
        logic signed [KEY_BITS-1:0] key;
        logic [1:0][7:0]            data;
        logic [1:0]                 has_data;
        logic                       has_pair;
        logic                       has_fin;
        logic [LENGTH_BITS-1:0]     length;
        logic [1:0]                 status;
    } grp_t;

endpackage

// File: rtl/dkvp_front.sv
// Front end: terminator detection, key scan and result grouping per request.
`timescale 1ns / 1ps

module dkvp_front
    import dkvp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_wr_t cfg,
    input  logic    push,
    input  in_req_t request,
    input  logic    q_full,
    output logic    grp_push,
    output grp_t    grp
);

    localparam logic [1:0] PH_START   = 2'd0;
    localparam logic [1:0] PH_KEY     = 2'd1;
    localparam logic [1:0] PH_VALUE   = 2'd2;
    localparam logic [1:0] PH_DISCARD = 2'd3;

    localparam logic [1:0] SCAN_LEAD   = 2'd0;
    localparam logic [1:0] SCAN_SIGN   = 2'd1;
    localparam logic [1:0] SCAN_DIGITS = 2'd2;
    localparam logic [1:0] SCAN_DONE   = 2'd3;

    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_DATA = 2'd1;
    localparam logic [1:0] EV_TERM = 2'd2;
    localparam logic [1:0] EV_ZERO = 2'd3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam int WIDE_BITS = KEY_BITS + 4;
    localparam logic [WIDE_BITS-1:0] KEY_CAP_WIDE =
        {{4{1'b0}}, 1'b1, {(KEY_BITS-1){1'b0}}};
    localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;

    typedef struct packed {
        logic [1:0]          scan;
        logic                neg;
        logic [KEY_BITS-1:0] mag;
    } key_state_t;

    typedef struct packed {
        logic [1:0]             phase;
        key_state_t             key;
        logic [LENGTH_BITS-1:0] count;
        grp_t                   grp;
        key_state_t             emit_key;
    } work_t;

    localparam key_state_t KEY_CLEAR = '{scan: SCAN_LEAD, neg: 1'b0, mag: '0};

    // Advance the key scan by one character; saturate the magnitude at 2^(KEY_BITS-1).
    function automatic key_state_t key_char(key_state_t s, logic [7:0] c);
        key_state_t           r;
        logic                 digit;
        logic                 space;
        logic                 accum;
        logic [7:0]           dval;
        logic [WIDE_BITS-1:0] wide;
        logic [WIDE_BITS-1:0] prod;
        r     = s;
        accum = 1'b0;
        digit = (c >= CH_0) && (c <= CH_9);
        space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        unique case (s.scan)
            SCAN_LEAD:
            begin
                priority if (space)
                begin
                    r.scan = SCAN_LEAD;
                end
                else if ((c == CH_PLUS) || (c == CH_MINUS))
                begin
                    r.neg  = (c == CH_MINUS);
                    r.scan = SCAN_SIGN;
                end
                else if (!digit)
                begin
                    r.scan = SCAN_DONE;
                end
                else
                begin
                    r.scan = SCAN_DIGITS;
                    accum  = 1'b1;
                end
            end
            SCAN_SIGN, SCAN_DIGITS:
            begin
                if (!digit)
                begin
                    r.scan = SCAN_DONE;
                end
                else
                begin
                    r.scan = SCAN_DIGITS;
                    accum  = 1'b1;
                end
            end
            SCAN_DONE:
            begin
                r.scan = SCAN_DONE;
            end
        endcase
        dval = c - CH_0;
        wide = {{4{1'b0}}, s.mag};
        prod = (wide << 3) + (wide << 1) + {{(WIDE_BITS-4){1'b0}}, dval[3:0]};
        if (accum)
        begin
            if (prod > KEY_CAP_WIDE)
            begin
                r.mag = KEY_CAP_WIDE[KEY_BITS-1:0];
            end
            else
            begin
                r.mag = prod[KEY_BITS-1:0];
            end
        end
        return r;
    endfunction

    function automatic logic [LENGTH_BITS-1:0] sat_inc(logic [LENGTH_BITS-1:0] n);
        return (n == LENGTH_MAX) ? n : n + LENGTH_BITS'(1);
    endfunction

    // Signed key value: negate, or clamp the positive side to the largest value.
    function automatic logic signed [KEY_BITS-1:0] key_now(key_state_t k);
        logic [KEY_BITS-1:0] r;
        priority if (k.neg)
        begin
            r = ~k.mag + KEY_BITS'(1);
        end
        else if (k.mag[KEY_BITS-1])
        begin
            r = {1'b0, {(KEY_BITS-1){1'b1}}};
        end
        else
        begin
            r = k.mag;
        end
        return $signed(r);
    endfunction

    // Apply one data byte, terminator or zero stop to the working state.
    function automatic work_t apply_event(work_t w, logic [1:0] ev, logic [7:0] c,
                                          logic slot);
        work_t r;
        r = w;
        unique case (ev)
            EV_NONE:
            begin
            end
            EV_DATA:
            begin
                unique case (w.phase)
                    PH_START, PH_KEY:
                    begin
                        r.phase = PH_KEY;
                        r.key   = key_char(w.key, c);
                    end
                    PH_VALUE:
                    begin
                        r.grp.has_data[slot] = 1'b1;
                        r.grp.data[slot]     = c;
                        r.emit_key           = w.key;
                        r.count              = sat_inc(w.count);
                    end
                    PH_DISCARD:
                    begin
                    end
                endcase
            end
            EV_TERM:
            begin
                unique case (w.phase)
                    PH_START:
                    begin
                        r.grp.has_fin = 1'b1;
                        r.grp.status  = ST_EMPTY_KEY;
                        r.phase       = PH_DISCARD;
                    end
                    PH_KEY:
                    begin
                        r.phase = PH_VALUE;
                        r.count = '0;
                    end
                    PH_VALUE:
                    begin
                        r.grp.has_pair = 1'b1;
                        r.grp.length   = w.count;
                        r.emit_key     = w.key;
                        r.key          = KEY_CLEAR;
                        r.count        = '0;
                        r.phase        = PH_START;
                    end
                    PH_DISCARD:
                    begin
                    end
                endcase
            end
            EV_ZERO:
            begin
                r.grp.has_fin = 1'b1;
                r.grp.status  = ST_ZERO_STOP;
                r.phase       = PH_DISCARD;
            end
        endcase
        return r;
    endfunction

    logic [1:0]             phase_reg, phase_next;
    key_state_t             key_reg, key_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;
    logic                   held_reg, held_next;
    logic [7:0]             term_first_reg, term_second_reg;
    logic                   accept;

    assign accept = push && !q_full;

    always_comb
    begin
        work_t w;
        logic  fresh;
        logic  hold_set;
        logic [1:0] ev1;
        logic [1:0] ev2;

        w.phase    = phase_reg;
        w.key      = key_reg;
        w.count    = count_reg;
        w.grp      = '0;
        w.emit_key = key_reg;
        held_next  = held_reg;

        // A held lead byte pairs with this byte, or is released as data.
        fresh    = !(held_reg && (request.byte_value == term_second_reg));
        ev1      = !held_reg ? EV_NONE : (fresh ? EV_DATA : EV_TERM);
        hold_set = 1'b0;
        priority if (!fresh)
        begin
            ev2 = EV_NONE;
        end
        else if (!held_reg && (phase_reg == PH_START) && (request.byte_value == CH_NUL))
        begin
            ev2 = EV_ZERO;
        end
        else if (request.byte_value == term_first_reg)
        begin
            if (request.payload_end)
            begin
                ev2 = EV_TERM;
            end
            else
            begin
                ev2      = EV_NONE;
                hold_set = 1'b1;
            end
        end
        else
        begin
            ev2 = EV_DATA;
        end

        if (phase_reg != PH_DISCARD)
        begin
            w         = apply_event(w, ev1, term_first_reg, 1'b0);
            w         = apply_event(w, ev2, request.byte_value, 1'b1);
            held_next = hold_set;
            if (request.payload_end)
            begin
                if ((w.phase == PH_KEY) || (w.phase == PH_VALUE))
                begin
                    w.grp.has_pair = 1'b1;
                    w.grp.length   = (w.phase == PH_VALUE) ? w.count : '0;
                    w.emit_key     = w.key;
                end
                if (w.phase != PH_DISCARD)
                begin
                    w.grp.has_fin = 1'b1;
                    w.grp.status  = ST_NORMAL;
                end
            end
        end

        // End of payload: drop all parser state back to pair start.
        if (request.payload_end)
        begin
            w.phase   = PH_START;
            w.key     = KEY_CLEAR;
            w.count   = '0;
            held_next = 1'b0;
        end

        w.grp.key  = key_now(w.emit_key);
        grp        = w.grp;
        grp_push   = accept && (w.grp.has_fin || w.grp.has_pair || (|w.grp.has_data));
        phase_next = w.phase;
        key_next   = w.key;
        count_next = w.count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            key_reg   <= KEY_CLEAR;
            count_reg <= '0;
            held_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            key_reg   <= key_next;
            count_reg <= count_next;
            held_reg  <= held_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_first_reg  <= TERM_FIRST_RESET;
            term_second_reg <= TERM_SECOND_RESET;
        end
        else if (cfg.en)
        begin
            unique case (cfg.index)
                CFG_TERM_FIRST:  term_first_reg  <= cfg.data;
                CFG_TERM_SECOND: term_second_reg <= cfg.data;
            endcase
        end
    end

endmodule

// File: rtl/dkvp_queue.sv
// Short group queue between the front end and the result sequencer.
`timescale 1ns / 1ps

module dkvp_queue
    import dkvp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  grp_t wr_grp,
    input  logic rd_en,
    output logic full,
    output logic empty,
    output grp_t rd_grp
);

    grp_t                 mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_BITS:0]   count_reg, count_next;
    logic                 do_wr, do_rd;

    assign full   = (count_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_grp = mem_reg[rd_ptr_reg];

    always_comb
    begin
        unique case ({do_wr, do_rd})
            2'b10:   count_next = count_reg + (QPTR_BITS+1)'(1);
            2'b01:   count_next = count_reg - (QPTR_BITS+1)'(1);
            2'b00:   count_next = count_reg;
            2'b11:   count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_grp;
        end
    end

endmodule

// File: rtl/dkvp_back.sv
// Result sequencer: unpacks the head group into single results in order.
`timescale 1ns / 1ps
`include "delimited_key_value_parser_core_assert.svh"

module dkvp_back
    import dkvp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_empty,
    input  grp_t    head,
    output logic    q_pop,
    input  logic    pop,
    output logic    empty,
    output result_t result
);

    localparam int SLOT_DATA0 = 0;
    localparam int SLOT_DATA1 = 1;
    localparam int SLOT_PAIR  = 2;
    localparam int SLOT_FIN   = 3;

    logic [3:0] done_reg, done_next;
    logic [3:0] rem;
    logic [3:0] cur;
    logic       take;

    always_comb
    begin
        rem    = {head.has_fin, head.has_pair, head.has_data} & ~done_reg;
        cur    = '0;
        result = '0;
        priority if (rem[SLOT_DATA0])
        begin
            cur[SLOT_DATA0]  = 1'b1;
            result.kind      = KIND_VALUE;
            result.pair_key  = head.key;
            result.data_byte = head.data[0];
        end
        else if (rem[SLOT_DATA1])
        begin
            cur[SLOT_DATA1]  = 1'b1;
            result.kind      = KIND_VALUE;
            result.pair_key  = head.key;
            result.data_byte = head.data[1];
        end
        else if (rem[SLOT_PAIR])
        begin
            cur[SLOT_PAIR]      = 1'b1;
            result.kind         = KIND_PAIR;
            result.pair_key     = head.key;
            result.value_length = head.length;
        end
        else if (rem[SLOT_FIN])
        begin
            cur[SLOT_FIN]        = 1'b1;
            result.kind          = KIND_FINISH;
            result.finish_status = head.status;
        end
        else
        begin
            cur = '0;
        end
        result.run_last = ((rem & ~cur) == '0);
    end

    assign empty = q_empty;
    assign take  = pop && !q_empty;
    assign q_pop = take && result.run_last;

    // Retire the group on its last result, else mark the slot as sent.
    always_comb
    begin
        priority if (!take)
        begin
            done_next = done_reg;
        end
        else if (result.run_last)
        begin
            done_next = '0;
        end
        else
        begin
            done_next = done_reg | cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= '0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    `DKVP_ASSERT_IMPLY(a_head_has_work, !q_empty, rem != 4'b0000)
    `DKVP_ASSERT_NEXT(a_group_stays, take && !result.run_last, !empty)
    `DKVP_ASSERT_NEXT(a_kind_order, take && !result.run_last, result.kind >= $past(result.kind))
    `DKVP_ASSERT_IMPLY(a_finish_closes, !empty && (result.kind == KIND_FINISH), result.run_last)

endmodule

// File: rtl/delimited_key_value_parser_core.sv
// Top level of the delimited key/value payload parser.
// Requests are payload bytes with an end-of-payload mark, pushed with push/full:
// a request is taken at a clock edge with push high and full low. Results are
// read with empty/pop: the oldest result sits on the result port while empty is
// low and is taken at an edge with pop high. Terminator bytes are written on the
// wr_en/wr_index/wr_data port, one register per edge; the user must write them
// only while the block is idle, as the block has no check for it. Each request
// yields zero to four results (value bytes, pair complete, payload finished);
// run_last marks the last result of a request. Throughput: one request per
// cycle while full is low, set by the combinational parse loop in the front end;
// a request with n results holds the result port for n pops.
// A four-entry group queue sits between front end and sequencer. When the
// receiver stalls, the queue fills and full rises; full then holds every request,
// including ones that would give no result, until a group retires.
// Reset: terminators return to 0xC0, 0x80, the parser to pair start, queue empty.
`timescale 1ns / 1ps

module delimited_key_value_parser_core
    import dkvp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [CFG_INDEX_BITS-1:0] wr_index,
    input  logic [7:0]                wr_data,
    input  logic                      push,
    output logic                      full,
    input  in_req_t                   request,
    input  logic                      pop,
    output logic                      empty,
    output result_t                   result
);

    cfg_wr_t cfg;
    logic    grp_push;
    grp_t    grp_in;
    grp_t    grp_head;
    logic    q_full;
    logic    q_empty;
    logic    q_pop;

    // Bundle the write port for the front end, which owns the terminator registers.
    assign cfg.en    = wr_en;
    assign cfg.index = wr_index;
    assign cfg.data  = wr_data;

    // Hold requests whenever the group queue has no room.
    assign full = q_full;

    // Front end: classify each byte and pack its results into one group.
    dkvp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .push     (push),
        .request  (request),
        .q_full   (q_full),
        .grp_push (grp_push),
        .grp      (grp_in)
    );

    // Decouple parsing from result delivery.
    dkvp_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (grp_push),
        .wr_grp (grp_in),
        .rd_en  (q_pop),
        .full   (q_full),
        .empty  (q_empty),
        .rd_grp (grp_head)
    );

    // Back end: advance through the head group one result per pop.
    dkvp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .head    (grp_head),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

// File: tb/delimited_key_value_parser_core_tb.sv
// Self-checking testbench for the delimited key/value payload parser core.
`timescale 1ns / 1ps

module delimited_key_value_parser_core_tb
    import dkvp_pkg::*;
();

    // Longest stretch with neither a request nor a result moving, well above a
    // receiver hold-off.
    localparam int STALL_LIMIT    = 4000;
    localparam int HOLDOFF_CYCLES = 200;
    // Cycles to let the front end and group queue go quiet before touching
    // the terminator registers.
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_ITEMS    = 12;

    // Tracks the parser state alongside the block, predicts every result of
    // each accepted request, and checks the results in order of arrival.
    class parse_scoreboard;
        typedef enum logic [1:0] {AT_PAIR_START, IN_KEY, IN_VALUE, DISCARDING} parse_phase_e;
        typedef enum logic [1:0] {SCAN_SPACE, SCAN_SIGNED, SCAN_DIGITS, SCAN_DONE} key_scan_e;

        logic [7:0]   term_first;
        logic [7:0]   term_second;
        parse_phase_e phase;
        key_scan_e    scan;
        bit           key_negative;
        bit           key_overflowed;
        bit           key_nonempty;
        bit           lead_held;
        bit [63:0]    key_magnitude;
        int unsigned  value_count;
        result_t      pending[$];
        int           failures;
        int           n_value;
        int           n_pair;
        int           n_finish;
        int           n_zero_stop;
        int           n_empty_key;

        function new();
            term_first  = TERM_FIRST_RESET;
            term_second = TERM_SECOND_RESET;
            failures    = 0;
            n_value     = 0;
            n_pair      = 0;
            n_finish    = 0;
            n_zero_stop = 0;
            n_empty_key = 0;
            clear_payload();
        endfunction

        function void clear_pair();
            scan           = SCAN_SPACE;
            key_negative   = 1'b0;
            key_magnitude  = '0;
            key_overflowed = 1'b0;
            key_nonempty   = 1'b0;
            value_count    = 0;
        endfunction

        function void clear_payload();
            phase     = AT_PAIR_START;
            lead_held = 1'b0;
            clear_pair();
        endfunction

        // Signed key as strtol would give it: positive side clamps one below
        // the cap, negative side wraps the magnitude (cap maps to the minimum).
        function logic signed [KEY_BITS-1:0] key_value();
            bit [63:0] cap;
            cap = 64'd1 << (KEY_BITS - 1);
            if (key_negative)
                return KEY_BITS'(64'd0 - key_magnitude);
            return (key_magnitude > cap - 1) ? KEY_BITS'(cap - 1) : KEY_BITS'(key_magnitude);
        endfunction

        function void expect_result(logic [1:0] kind, logic signed [KEY_BITS-1:0] key,
                                    logic [7:0] data, logic [LENGTH_BITS-1:0] len,
                                    logic [1:0] status);
            result_t r;
            r.kind          = kind;
            r.pair_key      = key;
            r.data_byte     = data;
            r.value_length  = len;
            r.finish_status = status;
            r.run_last      = 1'b0;
            pending.push_back(r);
            if (kind == KIND_VALUE)
                n_value++;
            else if (kind == KIND_PAIR)
                n_pair++;
            else
            begin
                n_finish++;
                if (status == ST_ZERO_STOP)
                    n_zero_stop++;
                if (status == ST_EMPTY_KEY)
                    n_empty_key++;
            end
        endfunction

        // One byte of key text: whitespace, sign, then digits; anything else
        // freezes the key where it stands.
        function void scan_key_byte(logic [7:0] c);
            bit        digit;
            bit [63:0] cap;
            bit [63:0] d;
            digit = (c >= "0" && c <= "9");
            case (scan)
                SCAN_SPACE:
                begin
                    // space or tab through carriage return
                    if (c == " " || (c >= 8'h09 && c <= 8'h0D))
                        return;
                    if (c == "+" || c == "-")
                    begin
                        key_negative = (c == "-");
                        scan = SCAN_SIGNED;
                        return;
                    end
                    if (!digit)
                    begin
                        scan = SCAN_DONE;
                        return;
                    end
                    scan = SCAN_DIGITS;
                end
                SCAN_SIGNED:
                begin
                    if (!digit)
                    begin
                        scan = SCAN_DONE;
                        return;
                    end
                    scan = SCAN_DIGITS;
                end
                SCAN_DIGITS:
                begin
                    if (!digit)
                    begin
                        scan = SCAN_DONE;
                        return;
                    end
                end
                default:
                    return;
            endcase
            cap = 64'd1 << (KEY_BITS - 1);
            d   = {56'd0, c} - {56'd0, 8'h30};
            if (key_magnitude > (cap - d) / 10)
            begin
                key_magnitude  = cap;
                key_overflowed = 1'b1;
            end
            else
            begin
                key_magnitude = key_magnitude * 10 + d;
                if (key_magnitude == cap && !key_negative)
                    key_overflowed = 1'b1;
            end
        endfunction

        function void take_data_byte(logic [7:0] c);
            case (phase)
                AT_PAIR_START:
                begin
                    phase = IN_KEY;
                    key_nonempty = 1'b1;
                    scan_key_byte(c);
                end
                IN_KEY:
                begin
                    key_nonempty = 1'b1;
                    scan_key_byte(c);
                end
                IN_VALUE:
                begin
                    expect_result(KIND_VALUE, key_value(), c, '0, ST_NORMAL);
                    if (value_count < (1 << LENGTH_BITS) - 1)
                        value_count++;
                end
                default:
                    ;
            endcase
        endfunction

        function void take_terminator();
            case (phase)
                AT_PAIR_START:
                begin
                    expect_result(KIND_FINISH, '0, '0, '0, ST_EMPTY_KEY);
                    phase = DISCARDING;
                end
                IN_KEY:
                begin
                    phase = IN_VALUE;
                    value_count = 0;
                end
                IN_VALUE:
                begin
                    expect_result(KIND_PAIR, key_value(), '0, LENGTH_BITS'(value_count),
                                  ST_NORMAL);
                    clear_pair();
                    phase = AT_PAIR_START;
                end
                default:
                    ;
            endcase
        endfunction

        // Predict every result of one accepted request and queue them.
        function void note_request(in_req_t r);
            int      first;
            bit      fresh;
            result_t tail;
            first = pending.size();
            fresh = 1'b1;
            if (phase == DISCARDING)
            begin
                if (r.payload_end)
                    clear_payload();
                return;
            end
            // A held lead byte resolves against the registers as they are now.
            if (lead_held)
            begin
                lead_held = 1'b0;
                if (r.byte_value == term_second)
                begin
                    take_terminator();
                    fresh = 1'b0;
                end
                else
                    take_data_byte(term_first);
            end
            if (fresh)
            begin
                if (phase == AT_PAIR_START && r.byte_value == 8'h00)
                begin
                    expect_result(KIND_FINISH, '0, '0, '0, ST_ZERO_STOP);
                    phase = DISCARDING;
                end
                else if (r.byte_value == term_first)
                begin
                    if (r.payload_end)
                        take_terminator();
                    else
                        lead_held = 1'b1;
                end
                else
                    take_data_byte(r.byte_value);
            end
            if (r.payload_end)
            begin
                if (phase == IN_KEY || phase == IN_VALUE)
                    expect_result(KIND_PAIR, key_value(), '0,
                                  (phase == IN_VALUE) ? LENGTH_BITS'(value_count)
                                                      : {LENGTH_BITS{1'b0}},
                                  ST_NORMAL);
                if (phase != DISCARDING)
                    expect_result(KIND_FINISH, '0, '0, '0, ST_NORMAL);
                clear_payload();
            end
            if (pending.size() > first)
            begin
                tail = pending.pop_back();
                tail.run_last = 1'b1;
                pending.push_back(tail);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            bit      bad;
            if (pending.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: kind %0d key %0d data %02h len %0d st %0d last %0b",
                             got.kind, got.pair_key, got.data_byte, got.value_length,
                             got.finish_status, got.run_last);
                return;
            end
            want = pending.pop_front();
            bad = (got.kind !== want.kind) || (got.pair_key !== want.pair_key)
               || (got.data_byte !== want.data_byte) || (got.value_length !== want.value_length)
               || (got.finish_status !== want.finish_status) || (got.run_last !== want.run_last);
            if (bad)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("mismatch: expected kind %0d key %0d data %02h len %0d st %0d last %0b",
                             want.kind, want.pair_key, want.data_byte, want.value_length,
                             want.finish_status, want.run_last);
                    $display("          actual   kind %0d key %0d data %02h len %0d st %0d last %0b",
                             got.kind, got.pair_key, got.data_byte, got.value_length,
                             got.finish_status, got.run_last);
                end
            end
        endfunction

        function void set_register(logic [CFG_INDEX_BITS-1:0] index, logic [7:0] value);
            if (index == CFG_TERM_FIRST)
                term_first = value;
            else if (index == CFG_TERM_SECOND)
                term_second = value;
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n    = 1'b0;
    logic                      wr_en    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] wr_index = '0;
    logic [7:0]                wr_data  = '0;
    logic                      push     = 1'b0;
    in_req_t                   request  = '0;
    logic                      pop      = 1'b0;
    logic                      full;
    logic                      empty;
    result_t                   result;

    parse_scoreboard sb;

    // Idle mix, in percent, for each side; the main sequence changes these.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    // Hold-offs are asked for by the main sequence and served by the receiver.
    int holdoffs_asked  = 0;
    int holdoffs_served = 0;
    int holdoff_left    = 0;

    int items_sent    = 0;
    int payloads_sent = 0;
    int settings_used = 0;

    // Payload under construction, one byte per request.
    logic [7:0] frame[$];

    delimited_key_value_parser_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_index(wr_index),
        .wr_data (wr_data),
        .push    (push),
        .full    (full),
        .request (request),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: check whatever was taken at this edge, then decide whether to
    // pop at the next one. A hold-off keeps pop low so the group queue fills.
    always @(posedge clk)
    begin
        if (pop && !empty)
            sb.check_result(result);
        if (holdoffs_served != holdoffs_asked)
        begin
            holdoffs_served = holdoffs_asked;
            holdoff_left = HOLDOFF_CYCLES;
        end
        if (holdoff_left > 0)
        begin
            holdoff_left--;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Watchdog: end the run if nothing moves on either side for too long.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: %0d cycles with nothing accepted", STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    // Offer one request, idling first at the current mix, and hold it until
    // the block takes it. push stays high on return so back-to-back requests
    // never drop it.
    task automatic send_request(logic [7:0] b, logic last);
        in_req_t r;
        r.byte_value  = b;
        r.payload_end = last;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        request <= r;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_request(r);
        items_sent++;
    endtask

    // Send the frame; with close set, mark its last byte as the payload end.
    task automatic send_frame(bit close);
        for (int i = 0; i < frame.size(); i++)
            send_request(frame[i], close && (i == frame.size() - 1));
        if (close)
            payloads_sent++;
    endtask

    // Pause the sender until every predicted result has been popped, then let
    // requests that give no result drain out of the front end.
    task automatic wait_idle();
        push <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Write both terminator registers on consecutive edges; wr_en stays high
    // across the pair.
    task automatic set_terminators(logic [7:0] first_byte, logic [7:0] second_byte);
        wr_en    <= 1'b1;
        wr_index <= CFG_TERM_FIRST;
        wr_data  <= first_byte;
        @(posedge clk);
        sb.set_register(CFG_TERM_FIRST, first_byte);
        wr_index <= CFG_TERM_SECOND;
        wr_data  <= second_byte;
        @(posedge clk);
        sb.set_register(CFG_TERM_SECOND, second_byte);
        wr_en <= 1'b0;
        settings_used++;
    endtask

    // Well-formed content must not contain the lead terminator byte by
    // accident; nudge such bytes off it.
    function automatic void append_byte(logic [7:0] b);
        frame.push_back((b == sb.term_first) ? (b ^ 8'h01) : b);
    endfunction

    function automatic void append_text(string s);
        for (int i = 0; i < s.len(); i++)
            append_byte(s[i]);
    endfunction

    function automatic void add_term();
        frame.push_back(sb.term_first);
        frame.push_back(sb.term_second);
    endfunction

    // Build one random payload. Most are well-formed pairs with random keys
    // and values ending in one of several ways; the rest stop on a zero byte
    // or a terminator at a pair start, or are plain noise.
    function automatic void build_payload();
        int         pairs;
        int         style;
        int         n;
        int         pick;
        logic [7:0] b;
        string      boundary[5] = '{"2147483647", "2147483648", "-2147483648",
                                    "-2147483649", "99999999999"};
        string      odd_keys[5] = '{"+", "-", " ", "-x", "x12"};
        frame.delete();
        style = $urandom_range(0, 11);
        if (style >= 10)
        begin
            // noise, with the lead terminator byte sprinkled in
            repeat ($urandom_range(1, 6))
                frame.push_back(($urandom_range(0, 2) == 0) ? sb.term_first
                                                            : 8'($urandom_range(0, 255)));
            return;
        end
        // 0..3 end after a full terminator, 4..5 inside a value, 6 inside a
        // key, 7 on a lone lead byte, 8 zero stop, 9 empty key
        pairs = $urandom_range((style >= 8) ? 0 : 1, 3);
        for (int p = 0; p < pairs; p++)
        begin
            pick = $urandom_range(0, 7);
            case (pick)
                0, 1:
                    append_text($sformatf("%0d", $urandom_range(0, 9999)));
                2:
                begin
                    repeat ($urandom_range(1, 2))
                    begin
                        b = 8'($urandom_range(0, 5));
                        append_byte((b == 0) ? 8'h20 : 8'h08 + b);
                    end
                    append_text($urandom_range(0, 1) ? "-" : "+");
                    append_text($sformatf("%0d", $urandom_range(0, 99999)));
                end
                3:
                    append_text(boundary[$urandom_range(0, 4)]);
                4:
                begin
                    // long digit strings can saturate the key
                    append_byte(8'("1" + $urandom_range(0, 8)));
                    repeat ($urandom_range(9, 11))
                        append_byte(8'("0" + $urandom_range(0, 9)));
                end
                5:
                    append_text($sformatf("%0d%c%0d", $urandom_range(0, 99),
                                          "a" + $urandom_range(0, 25), $urandom_range(0, 9)));
                6:
                    append_text(odd_keys[$urandom_range(0, 4)]);
                default:
                begin
                    append_byte(8'($urandom_range(1, 255)));
                    repeat ($urandom_range(0, 2))
                        append_byte(8'($urandom_range(0, 255)));
                end
            endcase
            if (p == pairs - 1 && style == 6)
                break;
            add_term();
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16) : $urandom_range(0, 5);
            repeat (n)
            begin
                if (sb.term_first != sb.term_second && $urandom_range(0, 7) == 0)
                begin
                    // lead byte not followed by the second one: plain data
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == sb.term_first || b == sb.term_second);
                    frame.push_back(sb.term_first);
                    frame.push_back(b);
                end
                else
                    append_byte(8'($urandom_range(0, 255)));
            end
            if (p < pairs - 1 || style <= 3 || style >= 8)
                add_term();
            else if (style == 7)
                frame.push_back(sb.term_first);
        end
        if (style == 8 || style == 9)
        begin
            if (style == 8)
                frame.push_back(8'h00);
            else
                add_term();
            // trailing bytes that the block must discard
            repeat ($urandom_range(0, 3))
                frame.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic run_random(int count);
        int target;
        target = items_sent + count;
        while (items_sent < target)
        begin
            build_payload();
            send_frame(1'b1);
        end
    endtask

    initial
    begin
        sb = new();

        // Hold reset, then release it on an edge.
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset terminators, first idle mix.
        tx_idle_pct = 19;
        rx_idle_pct = 59;
        // zero byte at pair start on the only byte of a payload
        frame = '{8'h00};
        send_frame(1'b1);
        // terminator at pair start, then a byte that must be discarded
        frame = '{TERM_FIRST_RESET, TERM_SECOND_RESET, 8'hFF};
        send_frame(1'b1);
        // negative key, all-ones value byte, lone lead byte closing the value
        frame = '{"-", "9", TERM_FIRST_RESET, TERM_SECOND_RESET, 8'hFF, TERM_FIRST_RESET};
        send_frame(1'b1);
        // lead byte without its partner inside a key, payload ends in a value
        frame = '{"7", TERM_FIRST_RESET, 8'h01, TERM_FIRST_RESET, TERM_SECOND_RESET};
        send_frame(1'b1);
        // payload ends inside a key
        frame = '{"3"};
        send_frame(1'b1);
        // leave a lead byte held, change the lead register, then resolve it
        frame = '{"1", TERM_FIRST_RESET, TERM_SECOND_RESET, "a", TERM_FIRST_RESET};
        send_frame(1'b0);
        wait_idle();
        set_terminators(8'h7E, TERM_SECOND_RESET);
        frame = '{"b"};
        send_frame(1'b1);

        // First idle mix: slow receiver. Start with a long receiver hold-off
        // while the sender keeps offering, so the queue fills and full rises.
        wait_idle();
        set_terminators(8'h00, 8'hFF);
        holdoffs_asked++;
        run_random(PHASE_ITEMS);
        wait_idle();
        set_terminators(";", 8'h0A);
        run_random(PHASE_ITEMS);

        // Second idle mix: slow sender.
        tx_idle_pct = 59;
        rx_idle_pct = 19;
        wait_idle();
        set_terminators(8'hFF, 8'h00);
        run_random(PHASE_ITEMS);
        wait_idle();
        set_terminators(",", ",");
        run_random(PHASE_ITEMS);

        // No idling on either side.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        wait_idle();
        set_terminators(TERM_FIRST_RESET, TERM_SECOND_RESET);
        holdoffs_asked++;
        run_random(PHASE_ITEMS);
        wait_idle();
        set_terminators(8'h0D, 8'h0A);
        run_random(PHASE_ITEMS);

        // Drain and settle, then report.
        wait_idle();
        if (sb.pending.size() != 0)
        begin
            $display("%0d expected results never arrived", sb.pending.size());
            sb.failures++;
        end
        $display("covered %0d requests in %0d payloads over %0d terminator settings",
                 items_sent, payloads_sent, settings_used);
        $display("checked %0d value bytes, %0d pairs, %0d finishes (%0d zero stops, %0d empty keys)",
                 sb.n_value, sb.n_pair, sb.n_finish, sb.n_zero_stop, sb.n_empty_key);
        if (sb.failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
